>>> rtl/ssrf_pkg.sv
`default_nettype none

package ssrf_pkg;

    localparam int FLOOR_COUNT = 3;
    // Buttons and sensors are three bits wide, so no more than three floors are scanned.
    localparam int FLOOR_SCAN  = (FLOOR_COUNT < 3) ? FLOOR_COUNT : 3;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int WIDTH_W = 12;
    localparam int STEP_W  = 8;
    localparam int TIME_W  = 16;
    localparam int FLOOR_W = 2;
    localparam int LAMP_W  = 3;
    localparam int CALC_W  = WIDTH_W + 2;

    localparam logic [WIDTH_W-1:0] STOP_RESET     = WIDTH_W'(1500);
    localparam logic [WIDTH_W-1:0] MIN_RESET      = WIDTH_W'(1000);
    localparam logic [WIDTH_W-1:0] MAX_RESET      = WIDTH_W'(2000);
    localparam logic [STEP_W-1:0]  STEP_RESET     = STEP_W'(10);
    localparam logic [TIME_W-1:0]  INTERVAL_RESET = TIME_W'(3000);
    localparam logic [TIME_W-1:0]  FRAME_RESET    = TIME_W'(20000);
    localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = TIME_W'(20000);

    localparam logic [FLOOR_W-1:0] FLOOR_ONE = FLOOR_W'(1);
    localparam logic [LAMP_W-1:0]  LAMP_ONE  = LAMP_W'(1);

    typedef enum logic [2:0] {
        REG_STOP_WIDTH    = 3'd0,
        REG_MIN_WIDTH     = 3'd1,
        REG_MAX_WIDTH     = 3'd2,
        REG_RAMP_STEP     = 3'd3,
        REG_STEP_INTERVAL = 3'd4,
        REG_FRAME_LENGTH  = 3'd5,
        REG_DEBOUNCE_TIME = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_DEBOUNCE = 3'd1,
        MODE_RELEASE  = 3'd2,
        MODE_OUT      = 3'd3,
        MODE_HOLD     = 3'd4,
        MODE_BACK     = 3'd5,
        MODE_SETTLE   = 3'd6
    } mode_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] stop_width;
        logic [WIDTH_W-1:0] min_width;
        logic [WIDTH_W-1:0] max_width;
        logic [STEP_W-1:0]  ramp_step;
        logic [TIME_W-1:0]  step_interval;
        logic [TIME_W-1:0]  frame_length;
        logic [TIME_W-1:0]  debounce_time;
    } cfg_t;

    typedef struct packed {
        logic [LAMP_W-1:0]  floor_lamps;
        logic [WIDTH_W-1:0] width_now;
        logic               moving;
        logic [FLOOR_W-1:0] floor_now;
    } ctrl_res_t;

    function automatic logic floor_low(input logic [LAMP_W-1:0] bits,
                                       input logic [FLOOR_W-1:0] floor_num);
        logic low;
        case (floor_num)
            2'd1:    low = ~bits[0];
            2'd2:    low = ~bits[1];
            2'd3:    low = ~bits[2];
            default: low = 1'b1;
        endcase
        return low;
    endfunction

    function automatic logic [LAMP_W-1:0] floor_lamp(input logic [FLOOR_W-1:0] floor_num);
        logic [LAMP_W-1:0] lamp;
        case (floor_num)
            2'd1:    lamp = 3'b001;
            2'd2:    lamp = 3'b010;
            2'd3:    lamp = 3'b100;
            default: lamp = 3'b000;
        endcase
        return lamp;
    endfunction

endpackage

`default_nettype wire

>>> rtl/servo_soft_ramp_floor_controller.sv
// Lift controller for a continuous-rotation servo, one input transfer per microsecond tick.
// Input channel: in_valid/in_stall with buttons_n and sensors_n (active low, bit0 floor one).
// Output channel: out_valid/out_stall with servo_level, floor_lamps, width_now, moving and
// floor_now; exactly one result per input transfer, in order.
// Configuration: APB-style port, seven registers at byte addresses 0..24; the user must
// write them only while no item is in flight, which the block does not enforce; pready is
// always high, reads return the stored value. An accepted item sits in the input register;
// when it advances, the control and PWM state step and the result is loaded into the
// output register, which holds out_valid high until the result is taken.
// Throughput: one item per cycle while out_stall is low; the next-state logic of the
// control and PWM state registers is a single pass of compares and one add per register.
// Stall: a stalled result holds in the output register while the input register still
// takes one more item; the input stalls only when both registers are full.
// Reset (rst_n low, asynchronous): idle, stop width 1500, floor one lamp, PWM low phase,
// all configuration registers at their defaults, both channels empty.
`default_nettype none

module servo_soft_ramp_floor_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssrf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ssrf_pkg::PDATA_W-1:0] pwdata,
    output logic      [ssrf_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ssrf_pkg::LAMP_W-1:0]  buttons_n,
    input  wire logic [ssrf_pkg::LAMP_W-1:0]  sensors_n,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             servo_level,
    output logic      [ssrf_pkg::LAMP_W-1:0]  floor_lamps,
    output logic      [ssrf_pkg::WIDTH_W-1:0] width_now,
    output logic                             moving,
    output logic      [ssrf_pkg::FLOOR_W-1:0] floor_now
);
    import ssrf_pkg::*;

    cfg_t              cfg;
    ctrl_res_t         ctrl_res;
    logic              pwm_level;

    logic              s1_valid_reg, s1_valid_next;
    logic [LAMP_W-1:0] buttons_reg;
    logic [LAMP_W-1:0] sensors_reg;
    logic              out_valid_reg, out_valid_next;
    ctrl_res_t         res_reg;
    logic              level_reg;

    logic              accept;
    logic              adv;

    assign adv      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = adv ? 1'b1 : (out_valid_reg && out_stall);

    ssrf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .buttons_n (buttons_reg),
        .sensors_n (sensors_reg),
        .cfg       (cfg),
        .res       (ctrl_res)
    );

    ssrf_pwm u_pwm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (adv),
        .width_now    (ctrl_res.width_now),
        .frame_length (cfg.frame_length),
        .level        (pwm_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buttons_reg <= buttons_n;
            sensors_reg <= sensors_n;
        end
        if (adv)
        begin
            res_reg   <= ctrl_res;
            level_reg <= pwm_level;
        end
    end

    assign out_valid   = out_valid_reg;
    assign servo_level = level_reg;
    assign floor_lamps = res_reg.floor_lamps;
    assign width_now   = res_reg.width_now;
    assign moving      = res_reg.moving;
    assign floor_now   = res_reg.floor_now;

`ifndef SYNTHESIS
    a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced item not presented at output");

    a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> s1_valid_reg)
        else $error("stalled input item dropped");

    a_lamp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(res_reg.floor_lamps))
        else $error("floor lamp not one-hot");

    a_floor_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.floor_lamps == floor_lamp(res_reg.floor_now)))
        else $error("lamp and floor disagree");
`endif

endmodule

`default_nettype wire

>>> rtl/ssrf_cfg.sv
`default_nettype none

module ssrf_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssrf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ssrf_pkg::PDATA_W-1:0] pwdata,
    output logic      [ssrf_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output ssrf_pkg::cfg_t                   cfg
);
    import ssrf_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_STOP_WIDTH:    cfg_next.stop_width    = pwdata[WIDTH_W-1:0];
                REG_MIN_WIDTH:     cfg_next.min_width     = pwdata[WIDTH_W-1:0];
                REG_MAX_WIDTH:     cfg_next.max_width     = pwdata[WIDTH_W-1:0];
                REG_RAMP_STEP:     cfg_next.ramp_step     = pwdata[STEP_W-1:0];
                REG_STEP_INTERVAL: cfg_next.step_interval = pwdata[TIME_W-1:0];
                REG_FRAME_LENGTH:  cfg_next.frame_length  = pwdata[TIME_W-1:0];
                REG_DEBOUNCE_TIME: cfg_next.debounce_time = pwdata[TIME_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_STOP_WIDTH:    prdata = PDATA_W'(cfg_reg.stop_width);
            REG_MIN_WIDTH:     prdata = PDATA_W'(cfg_reg.min_width);
            REG_MAX_WIDTH:     prdata = PDATA_W'(cfg_reg.max_width);
            REG_RAMP_STEP:     prdata = PDATA_W'(cfg_reg.ramp_step);
            REG_STEP_INTERVAL: prdata = PDATA_W'(cfg_reg.step_interval);
            REG_FRAME_LENGTH:  prdata = PDATA_W'(cfg_reg.frame_length);
            REG_DEBOUNCE_TIME: prdata = PDATA_W'(cfg_reg.debounce_time);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_width    <= STOP_RESET;
            cfg_reg.min_width     <= MIN_RESET;
            cfg_reg.max_width     <= MAX_RESET;
            cfg_reg.ramp_step     <= STEP_RESET;
            cfg_reg.step_interval <= INTERVAL_RESET;
            cfg_reg.frame_length  <= FRAME_RESET;
            cfg_reg.debounce_time <= DEBOUNCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/ssrf_ctrl.sv
`default_nettype none

module ssrf_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [ssrf_pkg::LAMP_W-1:0] buttons_n,
    input  wire logic [ssrf_pkg::LAMP_W-1:0] sensors_n,
    input  wire ssrf_pkg::cfg_t             cfg,
    output ssrf_pkg::ctrl_res_t             res
);
    import ssrf_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [TIME_W-1:0]  timer_reg, timer_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [FLOOR_W-1:0] target_reg, target_next;
    logic [FLOOR_W-1:0] prev_reg, prev_next;
    logic [LAMP_W-1:0]  lamp_reg, lamp_next;

    logic               up;
    logic               btn_low;
    logic               tgt_low;
    logic               btn_any;
    logic [FLOOR_W-1:0] btn_floor;
    logic [TIME_W-1:0]  timer_inc;
    logic [TIME_W-1:0]  limit;
    logic               timed;
    logic               tdone;
    logic               finish;
    logic               ev_out;
    logic               ev_back;

    logic signed [CALC_W-1:0] pw_s, st_s, stop_s, min_s, max_s;
    logic signed [CALC_W-1:0] step_out, step_back, out_p, back_q;
    logic [WIDTH_W-1:0]       end_w;
    logic                     out_past, back_past, hold_back_past;
    mode_t                    out_mode, back_mode;

    assign up      = target_reg > prev_reg;
    assign btn_low = floor_low(buttons_n, target_reg);
    assign tgt_low = floor_low(sensors_n, target_reg);

    // Lowest-numbered pressed button wins.
    always_comb
    begin
        btn_any   = 1'b0;
        btn_floor = target_reg;
        for (int f = FLOOR_SCAN; f >= 1; f--)
        begin
            if (!buttons_n[f-1])
            begin
                btn_any   = 1'b1;
                btn_floor = FLOOR_W'(f);
            end
        end
    end

    assign timed     = (mode_reg == MODE_DEBOUNCE) || (mode_reg == MODE_SETTLE) ||
                       (mode_reg == MODE_OUT) || (mode_reg == MODE_BACK);
    assign limit     = ((mode_reg == MODE_DEBOUNCE) || (mode_reg == MODE_SETTLE)) ?
                       cfg.debounce_time : cfg.step_interval;
    assign timer_inc = timer_reg + TIME_W'(1);
    assign tdone     = (timer_inc >= limit) || (timer_inc == '0);

    assign pw_s   = $signed({2'b00, width_reg});
    assign st_s   = $signed({{(CALC_W-STEP_W){1'b0}}, cfg.ramp_step});
    assign stop_s = $signed({2'b00, cfg.stop_width});
    assign min_s  = $signed({2'b00, cfg.min_width});
    assign max_s  = $signed({2'b00, cfg.max_width});

    assign step_out  = up ? (pw_s - st_s) : (pw_s + st_s);
    assign step_back = up ? (pw_s + st_s) : (pw_s - st_s);
    assign end_w     = up ? cfg.min_width : cfg.max_width;

    // Outward point: the first one is the stop width itself.
    assign out_p          = (mode_reg == MODE_RELEASE) ? stop_s : step_out;
    assign out_past       = up ? (out_p < min_s) : (out_p > max_s);
    assign hold_back_past = up ? (min_s > stop_s) : (max_s < stop_s);
    assign back_q         = (mode_reg == MODE_BACK) ? step_back : pw_s;
    assign back_past      = up ? (back_q > stop_s) : (back_q < stop_s);

    assign out_mode  = out_past ?
                       (tgt_low ? (hold_back_past ? MODE_SETTLE : MODE_BACK) : MODE_HOLD) :
                       (tgt_low ? MODE_SETTLE : MODE_OUT);
    assign back_mode = back_past ? MODE_SETTLE : MODE_BACK;

    assign ev_out  = ((mode_reg == MODE_RELEASE) && !btn_low && (target_reg != prev_reg)) ||
                     ((mode_reg == MODE_OUT) && tdone);
    assign ev_back = ((mode_reg == MODE_HOLD) && tgt_low) || ((mode_reg == MODE_BACK) && tdone);

    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_IDLE:
                if (btn_any)
                    mode_next = MODE_DEBOUNCE;
            MODE_DEBOUNCE:
                if (tdone)
                    mode_next = btn_low ? MODE_RELEASE : MODE_IDLE;
            MODE_RELEASE:
                if (!btn_low)
                    mode_next = (target_reg == prev_reg) ? MODE_SETTLE : out_mode;
            MODE_OUT:
                if (tdone)
                    mode_next = out_mode;
            MODE_HOLD:
                if (tgt_low)
                    mode_next = back_mode;
            MODE_BACK:
                if (tdone)
                    mode_next = back_mode;
            MODE_SETTLE:
                if (tdone)
                    mode_next = MODE_IDLE;
            default:
                mode_next = MODE_IDLE;
        endcase
    end

    assign finish = (mode_next == MODE_SETTLE) && (mode_reg != MODE_SETTLE);

    always_comb
    begin
        timer_next  = (timed && !tdone) ? timer_inc : '0;
        target_next = (mode_reg == MODE_IDLE) ? btn_floor : target_reg;
        prev_next   = finish ? target_reg : prev_reg;
        lamp_next   = finish ? floor_lamp(target_reg) : lamp_reg;
        if (finish)
            width_next = cfg.stop_width;
        else if (ev_out)
            width_next = out_past ? end_w : out_p[WIDTH_W-1:0];
        else if (ev_back)
            width_next = back_q[WIDTH_W-1:0];
        else
            width_next = width_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            timer_reg  <= '0;
            width_reg  <= STOP_RESET;
            target_reg <= FLOOR_ONE;
            prev_reg   <= FLOOR_ONE;
            lamp_reg   <= LAMP_ONE;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            timer_reg  <= timer_next;
            width_reg  <= width_next;
            target_reg <= target_next;
            prev_reg   <= prev_next;
            lamp_reg   <= lamp_next;
        end
    end

    assign res.floor_lamps = lamp_next;
    assign res.width_now   = width_next;
    assign res.moving      = (mode_next != MODE_IDLE);
    assign res.floor_now   = prev_next;

endmodule

`default_nettype wire

>>> rtl/ssrf_pwm.sv
`default_nettype none

module ssrf_pwm (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [ssrf_pkg::WIDTH_W-1:0] width_now,
    input  wire logic [ssrf_pkg::TIME_W-1:0]  frame_length,
    output logic                             level
);
    import ssrf_pkg::*;

    logic              high_reg, high_next;
    logic [TIME_W-1:0] ptimer_reg, ptimer_next;
    logic [TIME_W-1:0] plen_reg, plen_next;
    logic [TIME_W-1:0] ptimer_inc;
    logic [TIME_W-1:0] width_ext;
    logic [TIME_W-1:0] low_len;
    logic              phase_end;

    assign width_ext  = TIME_W'(width_now);
    assign low_len    = (frame_length > width_ext) ? (frame_length - width_ext) : '0;
    assign ptimer_inc = ptimer_reg + TIME_W'(1);
    // A zero length ends after one tick, the same as a length of one.
    assign phase_end  = (ptimer_inc >= plen_reg) || (ptimer_inc == '0);

    always_comb
    begin
        high_next   = high_reg;
        ptimer_next = ptimer_inc;
        plen_next   = plen_reg;
        if (phase_end)
        begin
            ptimer_next = '0;
            high_next   = ~high_reg;
            plen_next   = high_reg ? low_len : width_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg   <= 1'b0;
            ptimer_reg <= '0;
            plen_reg   <= TIME_W'(STOP_RESET);
        end
        else if (step)
        begin
            high_reg   <= high_next;
            ptimer_reg <= ptimer_next;
            plen_reg   <= plen_next;
        end
    end

    assign level = high_reg;

endmodule

`default_nettype wire

>>> tb/sv/servo_soft_ramp_floor_controller_test.sv
`timescale 1ns / 100ps

module servo_soft_ramp_floor_controller_test;

    import ssrf_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SHOWN_ERRORS = 20;

    typedef struct packed {
        logic               servo_level;
        logic [LAMP_W-1:0]  floor_lamps;
        logic [WIDTH_W-1:0] width_now;
        logic               moving;
        logic [FLOOR_W-1:0] floor_now;
    } lift_tick_t;

    class lift_scoreboard;
        cfg_t               cfg;
        mode_t              mode;
        logic [TIME_W-1:0]  mode_tmr;
        logic [WIDTH_W-1:0] width;
        logic [FLOOR_W-1:0] target;
        logic [FLOOR_W-1:0] last_floor;
        logic [LAMP_W-1:0]  lamps;
        logic               pwm_high;
        logic [TIME_W-1:0]  phase_tmr;
        logic [TIME_W-1:0]  phase_len;
        lift_tick_t         expected_ticks[$];
        int                 errors;

        function new();
            cfg.stop_width    = STOP_RESET;
            cfg.min_width     = MIN_RESET;
            cfg.max_width     = MAX_RESET;
            cfg.ramp_step     = STEP_RESET;
            cfg.step_interval = INTERVAL_RESET;
            cfg.frame_length  = FRAME_RESET;
            cfg.debounce_time = DEBOUNCE_RESET;
            mode       = MODE_IDLE;
            mode_tmr   = '0;
            width      = STOP_RESET;
            target     = FLOOR_ONE;
            last_floor = FLOOR_ONE;
            lamps      = LAMP_ONE;
            pwm_high   = 1'b0;
            phase_tmr  = '0;
            phase_len  = TIME_W'(STOP_RESET);
            errors     = 0;
        endfunction

        function bit is_low(logic [LAMP_W-1:0] bits, logic [FLOOR_W-1:0] f);
            return bits[f - 1] == 1'b0;
        endfunction

        function bit heading_up();
            return target > last_floor;
        endfunction

        function void finish_move();
            width      = cfg.stop_width;
            lamps      = LAMP_W'(1) << (target - 1);
            last_floor = target;
            mode       = MODE_SETTLE;
            mode_tmr   = '0;
        endfunction

        function void enter_back(int pw);
            if (heading_up() ? pw > int'(cfg.stop_width) : pw < int'(cfg.stop_width))
            begin
                finish_move();
                return;
            end
            width    = pw[WIDTH_W-1:0];
            mode     = MODE_BACK;
            mode_tmr = '0;
        endfunction

        function void enter_hold(logic [LAMP_W-1:0] sensors);
            width    = heading_up() ? cfg.min_width : cfg.max_width;
            mode     = MODE_HOLD;
            mode_tmr = '0;
            if (is_low(sensors, target))
                enter_back(int'(width));
        endfunction

        // An outward point past the end width means the ramp is over: go to hold.
        function void enter_out(int pw, logic [LAMP_W-1:0] sensors);
            if (heading_up() ? pw < int'(cfg.min_width) : pw > int'(cfg.max_width))
            begin
                enter_hold(sensors);
                return;
            end
            width = pw[WIDTH_W-1:0];
            if (is_low(sensors, target))
            begin
                finish_move();
                return;
            end
            mode     = MODE_OUT;
            mode_tmr = '0;
        endfunction

        function bit timer_expired(logic [TIME_W-1:0] limit);
            mode_tmr = mode_tmr + 1'b1;
            return mode_tmr >= limit || mode_tmr == '0;
        endfunction

        function void note_tick(logic [LAMP_W-1:0] buttons, logic [LAMP_W-1:0] sensors);
            int         pw;
            int         st;
            lift_tick_t t;
            pw = int'(width);
            st = int'(cfg.ramp_step);
            case (mode)
                MODE_IDLE:
                begin
                    if (buttons != '1)
                    begin
                        target   = !buttons[0] ? FLOOR_ONE : !buttons[1] ? 2'd2 : 2'd3;
                        mode     = MODE_DEBOUNCE;
                        mode_tmr = '0;
                    end
                end
                MODE_DEBOUNCE:
                begin
                    if (timer_expired(cfg.debounce_time))
                        mode = is_low(buttons, target) ? MODE_RELEASE : MODE_IDLE;
                end
                MODE_RELEASE:
                begin
                    if (!is_low(buttons, target))
                    begin
                        if (target == last_floor)
                            finish_move();
                        else
                            enter_out(int'(cfg.stop_width), sensors);
                    end
                end
                MODE_OUT:
                begin
                    if (timer_expired(cfg.step_interval))
                        enter_out(heading_up() ? pw - st : pw + st, sensors);
                end
                MODE_HOLD:
                begin
                    if (is_low(sensors, target))
                        enter_back(pw);
                end
                MODE_BACK:
                begin
                    if (timer_expired(cfg.step_interval))
                        enter_back(heading_up() ? pw + st : pw - st);
                end
                MODE_SETTLE:
                begin
                    if (timer_expired(cfg.debounce_time))
                        mode = MODE_IDLE;
                end
                default:
                    mode = MODE_IDLE;
            endcase

            // level is the one of the phase in force during this tick
            t.servo_level = pwm_high;
            phase_tmr = phase_tmr + 1'b1;
            if (phase_tmr >= phase_len || phase_tmr == '0)
            begin
                phase_tmr = '0;
                if (pwm_high)
                begin
                    pwm_high  = 1'b0;
                    phase_len = (cfg.frame_length > TIME_W'(width)) ?
                                cfg.frame_length - TIME_W'(width) : '0;
                end
                else
                begin
                    pwm_high  = 1'b1;
                    phase_len = TIME_W'(width);
                end
            end
            t.floor_lamps = lamps;
            t.width_now   = width;
            t.moving      = (mode != MODE_IDLE);
            t.floor_now   = last_floor;
            expected_ticks.push_back(t);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_tick(lift_tick_t got);
            lift_tick_t want;
            if (expected_ticks.size() == 0)
            begin
                report_mismatch("result transfer with nothing outstanding");
                return;
            end
            want = expected_ticks.pop_front();
            if (got.servo_level !== want.servo_level)
                report_mismatch($sformatf("servo_level %0d, expected %0d",
                                          got.servo_level, want.servo_level));
            if (got.floor_lamps !== want.floor_lamps)
                report_mismatch($sformatf("floor_lamps %b, expected %b",
                                          got.floor_lamps, want.floor_lamps));
            if (got.width_now !== want.width_now)
                report_mismatch($sformatf("width_now %0d, expected %0d",
                                          got.width_now, want.width_now));
            if (got.moving !== want.moving)
                report_mismatch($sformatf("moving %0d, expected %0d",
                                          got.moving, want.moving));
            if (got.floor_now !== want.floor_now)
                report_mismatch($sformatf("floor_now %0d, expected %0d",
                                          got.floor_now, want.floor_now));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [LAMP_W-1:0]  buttons_n;
    logic [LAMP_W-1:0]  sensors_n;
    logic               out_valid;
    logic               out_stall;
    logic               servo_level;
    logic [LAMP_W-1:0]  floor_lamps;
    logic [WIDTH_W-1:0] width_now;
    logic               moving;
    logic [FLOOR_W-1:0] floor_now;

    lift_scoreboard sb = new();
    int send_idle_pct;
    int stall_pct;
    int sent_items;
    int idle_in_pct[4]  = '{0, 50, 0, 8};
    int idle_out_pct[4] = '{0, 0, 50, 8};

    servo_soft_ramp_floor_controller u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .buttons_n  (buttons_n),
        .sensors_n  (sensors_n),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .servo_level(servo_level),
        .floor_lamps(floor_lamps),
        .width_now  (width_now),
        .moving     (moving),
        .floor_now  (floor_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: outputs are sampled as they stood at the edge.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_tick(lift_tick_t'({servo_level, floor_lamps, width_now,
                                            moving, floor_now}));
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic cfg_t mk_cfg(int stop, int lo, int hi, int step, int interval,
                                    int frame, int debounce);
        cfg_t c;
        c.stop_width    = WIDTH_W'(stop);
        c.min_width     = WIDTH_W'(lo);
        c.max_width     = WIDTH_W'(hi);
        c.ramp_step     = STEP_W'(step);
        c.step_interval = TIME_W'(interval);
        c.frame_length  = TIME_W'(frame);
        c.debounce_time = TIME_W'(debounce);
        return c;
    endfunction

    // Small widths and frames keep ramps short and the PWM toggling often.
    function automatic cfg_t random_cfg();
        int stop;
        int lo;
        int hi;
        stop = $urandom_range(10, 40);
        if ($urandom_range(4) == 0)
        begin
            lo = $urandom_range(80);
            hi = $urandom_range(80);
        end
        else
        begin
            lo = $urandom_range(stop);
            hi = $urandom_range(80, stop);
        end
        return mk_cfg(stop, lo, hi, $urandom_range(3, 15), $urandom_range(4),
                      $urandom_range(1, 100), $urandom_range(5));
    endfunction

    task automatic send_tick(logic [LAMP_W-1:0] buttons, logic [LAMP_W-1:0] sensors);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        buttons_n <= buttons;
        sensors_n <= sensors;
        do @(posedge clk); while (in_stall);
        sb.note_tick(buttons, sensors);
        sent_items++;
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (sb.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(cfg_t c);
        logic [PDATA_W-1:0] value;
        drain_pipe();
        for (int i = 0; i <= int'(REG_DEBOUNCE_TIME); i++)
        begin
            case (reg_idx_t'(i))
                REG_STOP_WIDTH:    value = PDATA_W'(c.stop_width);
                REG_MIN_WIDTH:     value = PDATA_W'(c.min_width);
                REG_MAX_WIDTH:     value = PDATA_W'(c.max_width);
                REG_RAMP_STEP:     value = PDATA_W'(c.ramp_step);
                REG_STEP_INTERVAL: value = PDATA_W'(c.step_interval);
                REG_FRAME_LENGTH:  value = PDATA_W'(c.frame_length);
                default:           value = PDATA_W'(c.debounce_time);
            endcase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PADDR_W'(i * 4);
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.cfg = c;
    endtask

    // One trip: press, release, travel with the target sensor high, arrive, settle.
    task automatic ride();
        logic [LAMP_W-1:0] pressed;
        logic [LAMP_W-1:0] mask;
        pressed = LAMP_W'($urandom_range(6));
        mask    = !pressed[0] ? 3'b001 : !pressed[1] ? 3'b010 : 3'b100;
        repeat ($urandom_range(1, 8))
            send_tick(pressed, LAMP_W'($urandom_range(7)));
        repeat ($urandom_range(1, 3))
            send_tick(LAMP_W'($urandom_range(7)) | mask, LAMP_W'($urandom_range(7)));
        repeat ($urandom_range(0, 25))
            send_tick('1, LAMP_W'($urandom_range(7)) | mask);
        repeat ($urandom_range(1, 6))
            send_tick('1, LAMP_W'($urandom_range(7)) & ~mask);
        repeat ($urandom_range(0, 8))
            send_tick('1, LAMP_W'($urandom_range(7)));
    endtask

    task automatic run_phase(cfg_t c, int idle_in, int idle_out, int items);
        int stop_at;
        load_config(c);
        send_idle_pct = idle_in;
        stall_pct     = idle_out;
        stop_at       = sent_items + items;
        while (sent_items < stop_at)
        begin
            if ($urandom_range(9) < 8)
                ride();
            else
                repeat ($urandom_range(1, 8))
                    send_tick(LAMP_W'($urandom_range(7)), LAMP_W'($urandom_range(7)));
            if ($urandom_range(29) == 0)
                drain_pipe();
        end
    endtask

    initial
    begin
        // {buttons_n, sensors_n}: same floor, priority, ramp out/hold/back, button
        // gone after debounce, target sensor already low at the first ramp point
        logic [5:0] script[26];
        script = '{
            {3'b000, 3'b000}, {3'b000, 3'b111}, {3'b000, 3'b111}, {3'b111, 3'b111},
            {3'b111, 3'b111}, {3'b111, 3'b111}, {3'b001, 3'b111}, {3'b001, 3'b111},
            {3'b001, 3'b111}, {3'b111, 3'b111}, {3'b111, 3'b111}, {3'b111, 3'b111},
            {3'b111, 3'b111}, {3'b111, 3'b101}, {3'b111, 3'b111}, {3'b111, 3'b111},
            {3'b111, 3'b111}, {3'b111, 3'b111}, {3'b111, 3'b111}, {3'b011, 3'b111},
            {3'b111, 3'b111}, {3'b111, 3'b111}, {3'b011, 3'b111}, {3'b011, 3'b111},
            {3'b011, 3'b111}, {3'b111, 3'b011}
        };
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        buttons_n     = '1;
        sensors_n     = '1;
        send_idle_pct = 0;
        stall_pct     = 0;
        sent_items    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_config(mk_cfg(20, 10, 30, 5, 1, 40, 2));
        foreach (script[k])
            send_tick(script[k][5:3], script[k][2:0]);

        // each phase ends only after a whole trip or burst, so it may run past its count
        for (int p = 0; p < 8; p++)
            run_phase(random_cfg(), idle_in_pct[p % 4], idle_out_pct[p % 4], 50);
        // all at the bottom, zero intervals, biggest step
        run_phase(mk_cfg(0, 0, 0, 255, 0, 1, 0), 50, 0, 20);
        // all at the top; the long debounce leaves the block waiting
        run_phase(mk_cfg(4095, 4095, 4095, 1, 65535, 65535, 65535), 0, 50, 20);
        // both end widths on the wrong side of stop, frame shorter than the min width
        run_phase(mk_cfg(2048, 4095, 0, 255, 1, 3000, 1), 8, 8, 30);

        drain_pipe();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ssrf_pkg.sv
rtl/ssrf_cfg.sv
rtl/ssrf_ctrl.sv
rtl/ssrf_pwm.sv
rtl/servo_soft_ramp_floor_controller.sv
tb/sv/servo_soft_ramp_floor_controller_test.sv
